// ===== rtl/core/stmk_pkg.sv =====
// Shared types and constants for the streaming min/max top-k ranker.
// No dependencies.
package stmk_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int SMALL_COUNT = 5;
  localparam int LARGE_COUNT = 4;
  localparam int FILL_W      = 3;

  typedef logic signed [VALUE_WIDTH-1:0] value_t;

  localparam value_t EMPTY_SMALL = value_t'(999999);
  localparam value_t EMPTY_LARGE = value_t'(-999999);

  // What one cell hands to its right-hand neighbor.
  typedef struct packed {
    logic   after;  // this slot is at or past the insert point
    value_t value;  // current slot contents
  } link_t;

endpackage

// ===== rtl/core/streaming_min_max_top_k.sv =====
// Streaming min/max top-k ranker, top level.
// Latency: the result word for an input word is valid the cycle after it is accepted.
// Throughput: one word per cycle while out_ready is high; all slots update together.
// Reset (rst_n low, synchronous): both fill counts go to zero, no result pending.
// Slot contents are not reset; unfilled slots read as the sentinels.
// Depends on stmk_pkg, stmk_list, stmk_cell.
module streaming_min_max_top_k import stmk_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_clear,
  input  value_t            in_value,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output value_t            out_small_0,
  output value_t            out_small_1,
  output value_t            out_small_2,
  output value_t            out_small_3,
  output value_t            out_small_4,
  output value_t            out_large_0,
  output value_t            out_large_1,
  output value_t            out_large_2,
  output value_t            out_large_3,
  output logic [FILL_W-1:0] out_small_used,
  output logic [FILL_W-1:0] out_large_used
);

  logic   accept;
  logic   out_valid_r;
  logic   out_valid_nxt;
  value_t small_slots [SMALL_COUNT];
  value_t large_slots [LARGE_COUNT];

  // The cell registers double as the output register: they only change on
  // an accept, and an accept only happens once the pending result is free
  // or is taken in the same cycle.
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  // ascending list of the smallest distinct words
  stmk_list #(
    .COUNT (SMALL_COUNT),
    .DESC  (1'b0),
    .EMPTY (EMPTY_SMALL)
  ) u_small (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .clear  (in_clear),
    .value  (in_value),
    .slots  (small_slots),
    .used   (out_small_used)
  );

  // descending list of the largest distinct words
  stmk_list #(
    .COUNT (LARGE_COUNT),
    .DESC  (1'b1),
    .EMPTY (EMPTY_LARGE)
  ) u_large (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .clear  (in_clear),
    .value  (in_value),
    .slots  (large_slots),
    .used   (out_large_used)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_small_0 = small_slots[0];
  assign out_small_1 = small_slots[1];
  assign out_small_2 = small_slots[2];
  assign out_small_3 = small_slots[3];
  assign out_small_4 = small_slots[4];
  assign out_large_0 = large_slots[0];
  assign out_large_1 = large_slots[1];
  assign out_large_2 = large_slots[2];
  assign out_large_3 = large_slots[3];

  // fill counts stay within their lists
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_small_used <= FILL_W'(SMALL_COUNT)) && (out_large_used <= FILL_W'(LARGE_COUNT)))
    else $error("fill count past list depth");

  // a clear leaves the new word as the only entry of both lists
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_clear |=> (out_small_used == FILL_W'(1)) && (out_large_used == FILL_W'(1))
      && (out_small_0 == $past(in_value)) && (out_large_0 == $past(in_value)))
    else $error("clear did not restart lists");

  // minimum never exceeds maximum
  a_min_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_small_used != '0) && (out_large_used != '0) |-> out_small_0 <= out_large_0)
    else $error("minimum above maximum");

  // a word is taken whenever no result is pending
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("stalled with empty output");

endmodule

// ===== rtl/core/stmk_cell.sv =====
// One compare-and-shift slot of a sorted list.
// Depends on stmk_pkg.
module stmk_cell import stmk_pkg::*; #(
  parameter bit DESC = 1'b0
) (
  input  logic   clk,
  input  logic   upd,
  input  logic   filled,
  input  value_t value,
  input  link_t  prev,
  output link_t  next,
  output logic   match,
  output value_t slot
);

  value_t slot_r;
  value_t slot_nxt;
  logic   take;
  logic   after;

  assign take  = filled && (DESC ? (slot_r < value) : (value < slot_r));
  assign after = take || !filled;
  assign match = filled && (slot_r == value);
  assign next  = '{after: after, value: slot_r};
  assign slot  = slot_r;

  // past the insert point: shift from the left; at it: take the new word
  assign slot_nxt = prev.after ? prev.value : value;

  always_ff @(posedge clk) begin
    if (upd && after) begin
      slot_r <= slot_nxt;
    end
  end

endmodule

// ===== rtl/core/stmk_list.sv =====
// One sorted list: a chain of stmk_cell slots plus its fill counter.
// Depends on stmk_pkg and stmk_cell.
module stmk_list import stmk_pkg::*; #(
  parameter int     COUNT = 5,
  parameter bit     DESC  = 1'b0,
  parameter value_t EMPTY = '0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              clear,
  input  value_t            value,
  output value_t            slots [COUNT],
  output logic [FILL_W-1:0] used
);

  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic [FILL_W-1:0] base;
  logic [COUNT-1:0]  filled;
  logic [COUNT-1:0]  match;
  link_t             link [COUNT+1];
  value_t            raw [COUNT];
  logic              dup;
  logic              upd;

  assign base = clear ? '0 : fill_r;
  assign dup  = |match;
  assign upd  = accept && !dup;
  assign link[0] = '{after: 1'b0, value: '0};

  for (genvar i = 0; i < COUNT; i++) begin : g_cell
    assign filled[i] = FILL_W'(i) < base;

    stmk_cell #(.DESC(DESC)) u_cell (
      .clk    (clk),
      .upd    (upd),
      .filled (filled[i]),
      .value  (value),
      .prev   (link[i]),
      .next   (link[i+1]),
      .match  (match[i]),
      .slot   (raw[i])
    );

    assign slots[i] = (FILL_W'(i) < fill_r) ? raw[i] : EMPTY;
  end

  always_comb begin
    fill_nxt = base;
    if (!dup && (base < FILL_W'(COUNT))) begin
      fill_nxt = base + FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (accept) begin
      fill_r <= fill_nxt;
    end
  end

  assign used = fill_r;

endmodule
